>>> hdl/yuvrgb_pkg.sv
// ----------------------------------------------------------------------------
// YUV 4:2:2 to RGB package
// Beat types, matrix codes, coefficient sets and the output clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package yuvrgb_pkg;

   localparam int SUM_W   = 28;
   localparam int COEF_W  = 18;
   localparam int LUMA_W  = 17;
   localparam int FRAC_W  = 16;
   localparam int CHROMA_W = 8;

   typedef enum logic [1:0] {
      MATRIX_BT601_STUDIO = 2'd0,
      MATRIX_BT709        = 2'd1,
      MATRIX_BT601_FULL   = 2'd2,
      MATRIX_SMPTE240M    = 2'd3
   } matrix_type;

   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] chroma_v;
      logic [7:0] luma_second;
      logic [7:0] chroma_u;
      logic       frame_end_in;
   } req_beat_type;

   typedef struct packed {
      logic [7:0] red_first;
      logic [7:0] green_first;
      logic [7:0] blue_first;
      logic [7:0] red_second;
      logic [7:0] green_second;
      logic [7:0] blue_second;
      logic       frame_end_out;
   } rsp_beat_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // all coefficients in Q.16; studio BT.601 integer set scaled by 256
   typedef struct packed {
      logic [COEF_W-1:0]       kr;
      logic [COEF_W-1:0]       kgu;
      logic [COEF_W-1:0]       kgv;
      logic [COEF_W-1:0]       kb;
      logic [LUMA_W-1:0]       ky;
      logic signed [SUM_W-1:0] ofs;
   } coef_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] r_term;
      logic signed [SUM_W-1:0] g_term;
      logic signed [SUM_W-1:0] b_term;
      matrix_type              matrix;
   } chroma_terms_type;

   function automatic coef_type coef_set(input matrix_type m);
      coef_type c;
      c.ky  = LUMA_W'(65536);
      c.ofs = '0;
      case (m)
         MATRIX_BT601_STUDIO: begin
            c.kr  = COEF_W'(104704);
            c.kgu = COEF_W'(25600);
            c.kgv = COEF_W'(53248);
            c.kb  = COEF_W'(132096);
            c.ky  = LUMA_W'(76288);
            // -16 * 298 * 256 plus the rounding half
            c.ofs = -SUM_W'(1187840);
         end
         MATRIX_BT709: begin
            c.kr  = COEF_W'(103206);
            c.kgu = COEF_W'(12276);
            c.kgv = COEF_W'(30679);
            c.kb  = COEF_W'(121609);
         end
         MATRIX_BT601_FULL: begin
            c.kr  = COEF_W'(91881);
            c.kgu = COEF_W'(22553);
            c.kgv = COEF_W'(46802);
            c.kb  = COEF_W'(116130);
         end
         MATRIX_SMPTE240M: begin
            c.kr  = COEF_W'(103285);
            c.kgu = COEF_W'(14877);
            c.kgv = COEF_W'(31261);
            c.kb  = COEF_W'(119669);
         end
         default: begin
            c.kr  = '0;
            c.kgu = '0;
            c.kgv = '0;
            c.kb  = '0;
         end
      endcase
      return c;
   endfunction

   // floor shift by FRAC_W, then saturate to 0..255
   function automatic logic [7:0] clamp_pixel(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-FRAC_W-1:0] q;
      logic [7:0]                     r;
      q = s[SUM_W-1:FRAC_W];
      if (q < 0) begin
         r = 8'd0;
      end else if (q > (SUM_W-FRAC_W)'(255)) begin
         r = 8'd255;
      end else begin
         r = q[7:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hdl/yuvrgb_chroma.sv
// ----------------------------------------------------------------------------
// YUV to RGB chroma stage
// Products of the centered chroma with the selected matrix, shared by lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module yuvrgb_chroma (
   input  wire logic                          clock,
   input  wire logic [7:0]                    chroma_v,
   input  wire logic [7:0]                    chroma_u,
   input  wire yuvrgb_pkg::matrix_type        matrix,
   output yuvrgb_pkg::chroma_terms_type       terms
);
   import yuvrgb_pkg::*;

   localparam int PROD_W = COEF_W + CHROMA_W + 1;

   coef_type                    coef;
   logic signed [CHROMA_W-1:0]  v_c;
   logic signed [CHROMA_W-1:0]  u_c;
   logic signed [PROD_W-1:0]    prod_r;
   logic signed [PROD_W-1:0]    prod_gu;
   logic signed [PROD_W-1:0]    prod_gv;
   logic signed [PROD_W-1:0]    prod_b;
   chroma_terms_type            terms_in;
   chroma_terms_type            terms_ff;

   always_comb begin
      coef = coef_set(matrix);
      // subtracting 128 from a byte is flipping its top bit
      v_c = $signed({~chroma_v[7], chroma_v[6:0]});
      u_c = $signed({~chroma_u[7], chroma_u[6:0]});
      prod_r  = PROD_W'($signed({1'b0, coef.kr})  * v_c);
      prod_gu = PROD_W'($signed({1'b0, coef.kgu}) * u_c);
      prod_gv = PROD_W'($signed({1'b0, coef.kgv}) * v_c);
      prod_b  = PROD_W'($signed({1'b0, coef.kb})  * u_c);
      terms_in.r_term = SUM_W'(prod_r);
      terms_in.g_term = -(SUM_W'(prod_gu) + SUM_W'(prod_gv));
      terms_in.b_term = SUM_W'(prod_b);
      terms_in.matrix = matrix;
   end

   always_ff @(posedge clock) begin
      terms_ff <= terms_in;
   end

   assign terms = terms_ff;

endmodule

`default_nettype wire

>>> hdl/yuvrgb_lane.sv
// ----------------------------------------------------------------------------
// YUV to RGB pixel lane
// Adds the scaled luma to the shared chroma terms and clamps one pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module yuvrgb_lane (
   input  wire logic                          clock,
   input  wire logic [7:0]                    luma,
   input  wire yuvrgb_pkg::chroma_terms_type  terms,
   output yuvrgb_pkg::pixel_type              pixel
);
   import yuvrgb_pkg::*;

   localparam int YPROD_W = LUMA_W + 10;

   coef_type                  coef;
   logic signed [YPROD_W-1:0] y_prod;
   logic signed [SUM_W-1:0]   y_base;
   pixel_type                 pixel_in;
   pixel_type                 pixel_ff;

   always_comb begin
      coef   = coef_set(terms.matrix);
      y_prod = YPROD_W'($signed({1'b0, coef.ky}) * $signed({1'b0, luma}));
      y_base = SUM_W'(y_prod) + coef.ofs;
      pixel_in.red   = clamp_pixel(y_base + terms.r_term);
      pixel_in.green = clamp_pixel(y_base + terms.g_term);
      pixel_in.blue  = clamp_pixel(y_base + terms.b_term);
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
   end

   assign pixel = pixel_ff;

endmodule

`default_nettype wire

>>> hdl/yuv422_to_rgb_converter_top.sv
// ----------------------------------------------------------------------------
// YUV 4:2:2 to RGB converter
// One macropixel in, two RGB pixels out over a two-stage pipeline.
//
//   channel  ports                         beat
//   req      start, busy, req_data         one macropixel
//   rsp      rsp_valid, rsp_data           two RGB pixels and frame end
//   csr      csr_wr_en, csr_wr_data        color matrix select
//
// One beat accepted per clock; busy is always low.
// Result passes the chroma multiply stage, then the lane add/clamp stage,
// and is shown for one cycle.
// Synchronous reset clears the pipeline valids and selects studio BT.601.
// ----------------------------------------------------------------------------
`default_nettype none

module yuv422_to_rgb_converter_top (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output      logic                     busy,
   input  wire yuvrgb_pkg::req_beat_type req_data,
   output      logic                     rsp_valid,
   output      yuvrgb_pkg::rsp_beat_type rsp_data,
   input  wire logic                     csr_wr_en,
   input  wire logic [1:0]               csr_wr_data
);
   import yuvrgb_pkg::*;

   matrix_type       matrix_ff;
   matrix_type       matrix_in;
   logic             valid1_ff;
   logic             valid2_ff;
   logic             valid1_in;
   logic [7:0]       luma_first_ff;
   logic [7:0]       luma_second_ff;
   logic             frame_end1_ff;
   logic             frame_end2_ff;
   chroma_terms_type terms;
   pixel_type        pixel_first;
   pixel_type        pixel_second;

   assign busy      = 1'b0;
   assign valid1_in = start & ~busy;
   assign matrix_in = csr_wr_en ? matrix_type'(csr_wr_data) : matrix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= MATRIX_BT601_STUDIO;
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         matrix_ff <= matrix_in;
         valid1_ff <= valid1_in;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      luma_first_ff  <= req_data.luma_first;
      luma_second_ff <= req_data.luma_second;
      frame_end1_ff  <= req_data.frame_end_in;
      frame_end2_ff  <= frame_end1_ff;
   end

   yuvrgb_chroma u_chroma (
      .clock    (clock),
      .chroma_v (req_data.chroma_v),
      .chroma_u (req_data.chroma_u),
      .matrix   (matrix_ff),
      .terms    (terms)
   );

   yuvrgb_lane u_lane_first (
      .clock (clock),
      .luma  (luma_first_ff),
      .terms (terms),
      .pixel (pixel_first)
   );

   yuvrgb_lane u_lane_second (
      .clock (clock),
      .luma  (luma_second_ff),
      .terms (terms),
      .pixel (pixel_second)
   );

   always_comb begin
      rsp_valid              = valid2_ff;
      rsp_data.red_first     = pixel_first.red;
      rsp_data.green_first   = pixel_first.green;
      rsp_data.blue_first    = pixel_first.blue;
      rsp_data.red_second    = pixel_second.red;
      rsp_data.green_second  = pixel_second.green;
      rsp_data.blue_second   = pixel_second.blue;
      rsp_data.frame_end_out = frame_end2_ff;
   end

endmodule

`default_nettype wire
